### sv/softmax_cross_entropy_loss_core_defines.svh
// Assertion macros shared by the checker of the loss core.
// Depends on nothing; the using scope must provide clk and arst_n.
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_CORE_DEFINES_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SCE_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sce assertion failed");

// Next-cycle implication, checked outside reset
`define SCE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sce assertion failed");

`endif

### sv/sce_pkg.sv
// Shared constants, types and reciprocal table of the softmax cross-entropy loss core.
// Used by the core and by its checker; depends on nothing.
package sce_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VOCAB_MAX = 4096;
	localparam int ADDR_W    = 12;
	localparam int VOCAB_W   = 13;
	localparam int LOGIT_W   = 32;
	localparam int TOKEN_W   = 16;
	localparam int COUNT_W   = 16;
	localparam int TOTAL_W   = 48;
	localparam int MUL_A_W   = 21;
	localparam int MUL_B_W   = 25;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W   = 48;
	localparam int DIV_D_W   = 24;
	localparam int DIV_C_W   = 6;

	// Fixed-point constants in Q16.16
	localparam logic [16:0] ONE_Q     = 17'h10000;
	localparam logic [15:0] LN2_Q     = 16'd45426;
	// exp(-x) is zero once x reaches 17 * ln2
	localparam logic [19:0] EXP_LIMIT = 20'd772242;
	// ceil(2^36 / LN2_Q): exact quotient for x below EXP_LIMIT
	localparam logic [20:0] RECIP_LN2 = 21'd1512779;

	// ceil(2^24 / d): exact quotient for dividends below 2^21
	function automatic logic [MUL_B_W-1:0] recip_small(input logic [3:0] d);
		logic [MUL_B_W-1:0] r;
		unique case (d)
			4'd1:    r = 25'd16777216;
			4'd2:    r = 25'd8388608;
			4'd3:    r = 25'd5592406;
			4'd4:    r = 25'd4194304;
			4'd5:    r = 25'd3355444;
			4'd6:    r = 25'd2796203;
			4'd7:    r = 25'd2396746;
			4'd8:    r = 25'd2097152;
			4'd9:    r = 25'd1864136;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef enum logic [22:0] {
		S_IDLE   = 23'd1,
		S_MAX    = 23'd2,
		S_EX_RD  = 23'd4,
		S_EX_K   = 23'd8,
		S_EX_R   = 23'd16,
		S_EX_TM  = 23'd32,
		S_EX_TD  = 23'd64,
		S_EX_TA  = 23'd128,
		S_EX_SH  = 23'd256,
		S_L_NORM = 23'd512,
		S_L_DIV  = 23'd1024,
		S_L_W    = 23'd2048,
		S_L_W2   = 23'd4096,
		S_L_TM   = 23'd8192,
		S_L_TD   = 23'd16384,
		S_L_TA   = 23'd32768,
		S_L_FIN  = 23'd65536,
		S_G_STEP = 23'd131072,
		S_B_DIV  = 23'd262144,
		S_ACC    = 23'd524288,
		S_BATCH  = 23'd1048576,
		S_M_DIV  = 23'd2097152,
		S_OUT    = 23'd4194304
	} state_t;

endpackage

### sv/softmax_cross_entropy_loss_core.sv
// Softmax cross-entropy loss core with GCD similarity bonus, Q16.16 fixed point.
// Depends on sce_pkg.
//
// Logits are taken one per cycle while the core is idle and written to a
// 4096-entry row buffer. When a row of row_len logits (0 counts as 1, more
// than 4096 as 4096) is complete and its target is valid, the core stops
// taking items and works the row through one shared multiplier and one shared
// restoring divider. The max pass sweeps the row. The exp pass reads each
// logit, reduces it by ln2 and sets up, then forms eight Taylor terms, each a
// multiply, a scaling by 1/n and an add, and last scales and adds; a logit too
// far below the maximum skips the Taylor terms. The logarithm then normalizes,
// divides and sums the atanh series. The bonus, when it applies, takes binary
// GCD steps and a divide; then the row's loss is accumulated. A row with
// an invalid target, or a mid-row item, goes back to idle, or to the batch
// close on a marker. Closing the batch starts a mean divide if any row counted.
// The result then waits in the output register until taken, and no item is taken meanwhile.
module softmax_cross_entropy_loss_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [sce_pkg::LOGIT_W-1:0] logit_value,
	input  logic        [sce_pkg::TOKEN_W-1:0] target_token,
	input  logic                               last_in_batch,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sce_pkg::LOGIT_W-1:0] mean_loss,
	output logic        [sce_pkg::COUNT_W-1:0] rows_counted,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [sce_pkg::VOCAB_W-1:0] row_len
);

	sce_pkg::state_t state_q;

	// Row buffer
	logic signed [sce_pkg::LOGIT_W-1:0] mem [sce_pkg::VOCAB_MAX];
	logic signed [sce_pkg::LOGIT_W-1:0] mem_q;
	logic        [sce_pkg::ADDR_W-1:0]  rd_addr;

	// Control and datapath registers
	logic [sce_pkg::VOCAB_W-1:0]        vocab_q;
	logic [sce_pkg::VOCAB_W-1:0]        n_q;
	logic [sce_pkg::ADDR_W-1:0]         idx_q;
	logic [sce_pkg::TOKEN_W-1:0]        row_tgt_q;
	logic [sce_pkg::TOKEN_W-1:0]        prev_q;
	logic                               have_prev_q;
	logic                               last_q;
	logic signed [sce_pkg::TOTAL_W-1:0] total_q;
	logic [sce_pkg::COUNT_W-1:0]        count_q;
	logic [sce_pkg::VOCAB_W-1:0]        cnt_q;
	logic                               rd_vld_s1;
	logic [sce_pkg::ADDR_W-1:0]         rd_idx_s1;
	logic signed [sce_pkg::LOGIT_W-1:0] mx_q;
	logic signed [sce_pkg::LOGIT_W-1:0] tl_q;
	logic [sce_pkg::ADDR_W-1:0]         v_q;
	logic [19:0]                        x_q;
	logic [4:0]                         ek_q;
	logic [15:0]                        r_q;
	logic [16:0]                        et_q;
	logic signed [18:0]                 es_q;
	logic [3:0]                         en_q;
	logic [28:0]                        rs_q;
	logic [3:0]                         lm_q;
	logic [16:0]                        z_q;
	logic [16:0]                        lw_q;
	logic [16:0]                        lt_q;
	logic [18:0]                        acc_q;
	logic [3:0]                         ld_q;
	logic signed [34:0]                 ce_q;
	logic [12:0]                        ga_q;
	logic [12:0]                        gb_q;
	logic [3:0]                         gk_q;
	logic [16:0]                        bonus_q;
	logic                               neg_q;
	logic                               out_valid_q;
	logic signed [sce_pkg::LOGIT_W-1:0] mean_q;
	logic [sce_pkg::COUNT_W-1:0]        rows_q;

	// Shared multiplier
	logic [sce_pkg::MUL_A_W-1:0] mul_a;
	logic [sce_pkg::MUL_B_W-1:0] mul_b;
	logic [sce_pkg::MUL_P_W-1:0] mul_q;

	// Shared divider
	logic                        dv_start;
	logic [sce_pkg::DIV_N_W-1:0] dv_num;
	logic [sce_pkg::DIV_D_W-1:0] dv_dnm;
	logic [sce_pkg::DIV_N_W-1:0] dv_quo_q;
	logic [sce_pkg::DIV_D_W-1:0] dv_rem_q;
	logic [sce_pkg::DIV_D_W-1:0] dv_den_q;
	logic [sce_pkg::DIV_C_W-1:0] dv_cnt_q;
	logic [sce_pkg::DIV_D_W:0]   dv_sh;
	logic                        dv_ge;
	logic                        dv_done;

	// Combinational helpers
	logic                        in_acc;
	logic [sce_pkg::VOCAB_W-1:0] n_eff;
	logic [sce_pkg::VOCAB_W-1:0] idx_next;
	logic [sce_pkg::TOKEN_W-1:0] row_tgt_now;
	logic                        row_done;
	logic                        tgt_ok;
	logic [32:0]                 x_full;
	logic                        x_big;
	logic [4:0]                  k_now;
	logic [20:0]                 k_ln2;
	logic [17:0]                 exp_val;
	logic [16:0]                 norm_y;
	logic [20:0]                 lm_ln2;
	logic [20:0]                 ln_val;
	logic [32:0]                 mx_diff;
	logic                        bonus_ok;
	logic [12:0]                 g_val;
	logic [12:0]                 big_val;
	logic signed [35:0]          loss;
	logic signed [48:0]          tot_sum;
	logic [sce_pkg::TOTAL_W-1:0] tot_mag;
	logic [sce_pkg::DIV_N_W-1:0] q_val;

	assign in_ready     = (state_q == sce_pkg::S_IDLE);
	assign cfg_ready    = (state_q == sce_pkg::S_IDLE);
	assign out_valid    = out_valid_q;
	assign mean_loss    = mean_q;
	assign rows_counted = rows_q;

	assign in_acc = in_valid && in_ready;
	assign n_eff  = (vocab_q == '0) ? 13'd1 :
		((vocab_q > 13'(sce_pkg::VOCAB_MAX)) ? 13'(sce_pkg::VOCAB_MAX) : vocab_q);
	assign idx_next    = {1'b0, idx_q} + 13'd1;
	assign row_tgt_now = (idx_q == '0) ? target_token : row_tgt_q;
	assign row_done    = (idx_next >= n_eff);
	assign tgt_ok      = (row_tgt_now < {3'b0, n_eff});

	// Exp range reduction
	assign x_full  = {mx_q[31], mx_q} - {mem_q[31], mem_q};
	assign x_big   = (x_full >= {13'b0, sce_pkg::EXP_LIMIT});
	assign k_now   = mul_q[40:36];
	assign k_ln2   = 21'(k_now) * 21'(sce_pkg::LN2_Q);
	assign exp_val = es_q[18] ? 18'd0 : (es_q[17:0] >> ek_q);

	// Log and row loss
	assign norm_y  = rs_q[16:0];
	assign lm_ln2  = 21'(lm_q) * 21'(sce_pkg::LN2_Q);
	assign ln_val  = lm_ln2 + {1'b0, acc_q, 1'b0};
	assign mx_diff = {mx_q[31], mx_q} - {tl_q[31], tl_q};
	assign bonus_ok = have_prev_q && (prev_q < {3'b0, n_q}) &&
		(row_tgt_q != '0) && (prev_q != '0);
	assign g_val   = 13'({16'b0, ga_q} << gk_q);
	assign big_val = ((row_tgt_q > prev_q) ? row_tgt_q[12:0] : prev_q[12:0]) + 13'd1;
	assign loss    = {ce_q[34], ce_q} - {19'b0, bonus_q};
	assign tot_sum = {total_q[47], total_q} + {{13{loss[35]}}, loss};
	assign tot_mag = total_q[47] ? (48'd0 - total_q) : total_q;
	assign q_val   = dv_quo_q;

	// Read address: max pass sweeps, exp pass steps
	assign rd_addr = (state_q == sce_pkg::S_MAX) ? cnt_q[11:0] : v_q;

	// Row buffer write and registered read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[idx_q] <= logit_value;
		end
		mem_q <= mem[rd_addr];
	end

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			sce_pkg::S_EX_K: begin
				mul_a = {1'b0, x_full[19:0]};
				mul_b = {4'b0, sce_pkg::RECIP_LN2};
			end
			sce_pkg::S_EX_TM: begin
				mul_a = {4'b0, et_q};
				mul_b = {9'b0, r_q};
			end
			sce_pkg::S_EX_TD: begin
				mul_a = {4'b0, mul_q[32:16]};
				mul_b = sce_pkg::recip_small(en_q);
			end
			sce_pkg::S_L_W: begin
				mul_a = {4'b0, z_q};
				mul_b = {8'b0, z_q};
			end
			sce_pkg::S_L_TM: begin
				mul_a = {4'b0, lt_q};
				mul_b = {8'b0, lw_q};
			end
			sce_pkg::S_L_TD: begin
				mul_a = {4'b0, mul_q[32:16]};
				mul_b = sce_pkg::recip_small(ld_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= sce_pkg::MUL_P_W'(mul_a) * sce_pkg::MUL_P_W'(mul_b);
	end

	// Select divider operands and start
	always_comb begin
		dv_start = 1'b0;
		dv_num   = '0;
		dv_dnm   = '0;
		if (state_q == sce_pkg::S_L_NORM && rs_q[28:17] == '0) begin
			dv_start = 1'b1;
			dv_num   = {16'b0, 16'(norm_y - sce_pkg::ONE_Q), 16'b0};
			dv_dnm   = {6'b0, {1'b0, norm_y} + {1'b0, sce_pkg::ONE_Q}};
		end else if (state_q == sce_pkg::S_G_STEP && ga_q == gb_q) begin
			dv_start = 1'b1;
			dv_num   = 48'({g_val, 16'b0}) + 48'(19'(big_val) * 19'd50);
			dv_dnm   = 24'(20'(big_val) * 20'd100);
		end else if (state_q == sce_pkg::S_BATCH && count_q != '0) begin
			dv_start = 1'b1;
			dv_num   = tot_mag;
			dv_dnm   = {8'b0, count_q};
		end
	end

	// Restoring divider, one quotient bit per cycle
	assign dv_sh   = {dv_rem_q, dv_quo_q[47]};
	assign dv_ge   = (dv_sh >= {1'b0, dv_den_q});
	assign dv_done = (dv_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_cnt_q <= '0;
			dv_quo_q <= '0;
			dv_rem_q <= '0;
			dv_den_q <= '0;
		end else if (dv_start) begin
			dv_cnt_q <= 6'(sce_pkg::DIV_N_W);
			dv_quo_q <= dv_num;
			dv_rem_q <= '0;
			dv_den_q <= dv_dnm;
		end else if (!dv_done) begin
			dv_cnt_q <= dv_cnt_q - 6'd1;
			dv_quo_q <= {dv_quo_q[46:0], dv_ge};
			dv_rem_q <= dv_ge ? 24'(dv_sh - {1'b0, dv_den_q}) : dv_sh[23:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sce_pkg::S_IDLE;
			vocab_q     <= 13'(sce_pkg::VOCAB_MAX);
			n_q         <= 13'(sce_pkg::VOCAB_MAX);
			idx_q       <= '0;
			row_tgt_q   <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			total_q     <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			mx_q        <= '0;
			tl_q        <= '0;
			v_q         <= '0;
			x_q         <= '0;
			ek_q        <= '0;
			r_q         <= '0;
			et_q        <= '0;
			es_q        <= '0;
			en_q        <= '0;
			rs_q        <= '0;
			lm_q        <= '0;
			z_q         <= '0;
			lw_q        <= '0;
			lt_q        <= '0;
			acc_q       <= '0;
			ld_q        <= '0;
			ce_q        <= '0;
			ga_q        <= '0;
			gb_q        <= '0;
			gk_q        <= '0;
			bonus_q     <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			rows_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vocab_q <= row_len;
			end
			unique case (state_q)
				// Take an item; close the row when it is full, or the batch on a marker
				sce_pkg::S_IDLE: begin
					if (in_acc) begin
						last_q <= last_in_batch;
						if (idx_q == '0) begin
							row_tgt_q <= target_token;
						end
						if (row_done) begin
							idx_q <= '0;
							n_q   <= n_eff;
							if (tgt_ok) begin
								cnt_q     <= '0;
								rd_vld_s1 <= 1'b0;
								rs_q      <= '0;
								lm_q      <= '0;
								state_q   <= sce_pkg::S_MAX;
							end else begin
								prev_q      <= row_tgt_now;
								have_prev_q <= 1'b1;
								state_q <= last_in_batch ? sce_pkg::S_BATCH : sce_pkg::S_IDLE;
							end
						end else begin
							idx_q   <= idx_next[11:0];
							state_q <= last_in_batch ? sce_pkg::S_BATCH : sce_pkg::S_IDLE;
						end
					end
				end
				// Sweep the row for the maximum and the target logit
				sce_pkg::S_MAX: begin
					rd_vld_s1 <= (cnt_q < n_q);
					rd_idx_s1 <= cnt_q[11:0];
					cnt_q     <= cnt_q + 13'd1;
					if (rd_vld_s1) begin
						if (rd_idx_s1 == '0 || mem_q > mx_q) begin
							mx_q <= mem_q;
						end
						if (rd_idx_s1 == row_tgt_q[11:0]) begin
							tl_q <= mem_q;
						end
						if (rd_idx_s1 == 12'(n_q - 13'd1)) begin
							v_q     <= '0;
							state_q <= sce_pkg::S_EX_RD;
						end
					end
				end
				sce_pkg::S_EX_RD: begin
					state_q <= sce_pkg::S_EX_K;
				end
				// Drop far-off logits, else reduce by ln2
				sce_pkg::S_EX_K: begin
					if (x_big) begin
						es_q    <= '0;
						ek_q    <= '0;
						state_q <= sce_pkg::S_EX_SH;
					end else begin
						x_q     <= x_full[19:0];
						state_q <= sce_pkg::S_EX_R;
					end
				end
				sce_pkg::S_EX_R: begin
					ek_q    <= k_now;
					r_q     <= 16'(x_q - k_ln2[19:0]);
					et_q    <= sce_pkg::ONE_Q;
					es_q    <= 19'sd65536;
					en_q    <= 4'd1;
					state_q <= sce_pkg::S_EX_TM;
				end
				sce_pkg::S_EX_TM: begin
					state_q <= sce_pkg::S_EX_TD;
				end
				sce_pkg::S_EX_TD: begin
					state_q <= sce_pkg::S_EX_TA;
				end
				// Add the next Taylor term with alternating sign
				sce_pkg::S_EX_TA: begin
					et_q <= mul_q[40:24];
					if (en_q[0]) begin
						es_q <= es_q - $signed({2'b0, mul_q[40:24]});
					end else begin
						es_q <= es_q + $signed({2'b0, mul_q[40:24]});
					end
					en_q    <= en_q + 4'd1;
					state_q <= (en_q == 4'd8) ? sce_pkg::S_EX_SH : sce_pkg::S_EX_TM;
				end
				// Scale by 2^-k and accumulate
				sce_pkg::S_EX_SH: begin
					rs_q <= rs_q + 29'(exp_val);
					if (v_q == 12'(n_q - 13'd1)) begin
						state_q <= sce_pkg::S_L_NORM;
					end else begin
						v_q     <= v_q + 12'd1;
						state_q <= sce_pkg::S_EX_RD;
					end
				end
				// Normalize the sum into [1, 2)
				sce_pkg::S_L_NORM: begin
					if (rs_q[28:17] != '0) begin
						rs_q <= rs_q >> 1;
						lm_q <= lm_q + 4'd1;
					end else begin
						state_q <= sce_pkg::S_L_DIV;
					end
				end
				sce_pkg::S_L_DIV: begin
					if (dv_done) begin
						z_q     <= q_val[16:0];
						state_q <= sce_pkg::S_L_W;
					end
				end
				sce_pkg::S_L_W: begin
					state_q <= sce_pkg::S_L_W2;
				end
				sce_pkg::S_L_W2: begin
					lw_q    <= mul_q[32:16];
					lt_q    <= z_q;
					acc_q   <= {2'b0, z_q};
					ld_q    <= 4'd3;
					state_q <= sce_pkg::S_L_TM;
				end
				sce_pkg::S_L_TM: begin
					state_q <= sce_pkg::S_L_TD;
				end
				sce_pkg::S_L_TD: begin
					lt_q    <= mul_q[32:16];
					state_q <= sce_pkg::S_L_TA;
				end
				// Add the next odd term of the atanh series
				sce_pkg::S_L_TA: begin
					acc_q   <= acc_q + 19'(mul_q[40:24]);
					ld_q    <= ld_q + 4'd2;
					state_q <= (ld_q == 4'd9) ? sce_pkg::S_L_FIN : sce_pkg::S_L_TM;
				end
				// Form the cross-entropy and decide on the bonus
				sce_pkg::S_L_FIN: begin
					ce_q <= $signed(35'(ln_val) + 35'(mx_diff[31:0]));
					if (bonus_ok) begin
						ga_q    <= row_tgt_q[12:0] + 13'd1;
						gb_q    <= prev_q[12:0] + 13'd1;
						gk_q    <= '0;
						state_q <= sce_pkg::S_G_STEP;
					end else begin
						bonus_q <= '0;
						state_q <= sce_pkg::S_ACC;
					end
				end
				// Binary GCD step
				sce_pkg::S_G_STEP: begin
					priority if (ga_q == gb_q) begin
						state_q <= sce_pkg::S_B_DIV;
					end else if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gk_q <= gk_q + 4'd1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q > gb_q) begin
						ga_q <= (ga_q - gb_q) >> 1;
					end else begin
						gb_q <= (gb_q - ga_q) >> 1;
					end
				end
				sce_pkg::S_B_DIV: begin
					if (dv_done) begin
						bonus_q <= q_val[16:0];
						state_q <= sce_pkg::S_ACC;
					end
				end
				// Add the row loss with saturation
				sce_pkg::S_ACC: begin
					if (tot_sum[48] != tot_sum[47]) begin
						total_q <= tot_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
					end else begin
						total_q <= tot_sum[47:0];
					end
					if (count_q != '1) begin
						count_q <= count_q + 16'd1;
					end
					prev_q      <= row_tgt_q;
					have_prev_q <= 1'b1;
					state_q <= last_q ? sce_pkg::S_BATCH : sce_pkg::S_IDLE;
				end
				// Close the batch and start the mean, or report a zero mean for an empty batch
				sce_pkg::S_BATCH: begin
					idx_q       <= '0;
					have_prev_q <= 1'b0;
					rows_q      <= count_q;
					neg_q       <= total_q[47];
					total_q     <= '0;
					count_q     <= '0;
					if (count_q == '0) begin
						mean_q      <= '0;
						out_valid_q <= 1'b1;
						state_q     <= sce_pkg::S_OUT;
					end else begin
						state_q <= sce_pkg::S_M_DIV;
					end
				end
				// Saturate the mean to 32 bits
				sce_pkg::S_M_DIV: begin
					if (dv_done) begin
						if (neg_q) begin
							mean_q <= (q_val > 48'h80000000) ? 32'sh80000000 :
								$signed(32'(48'd0 - q_val));
						end else begin
							mean_q <= (q_val > 48'h7FFFFFFF) ? 32'sh7FFFFFFF :
								$signed(q_val[31:0]);
						end
						out_valid_q <= 1'b1;
						state_q     <= sce_pkg::S_OUT;
					end
				end
				// Hold the result until taken
				sce_pkg::S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= sce_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= sce_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/sce_checker.sv
// Port-level checker of the softmax cross-entropy loss core, bound to the core module.
// Depends on sce_pkg and softmax_cross_entropy_loss_core_defines.svh.
`include "softmax_cross_entropy_loss_core_defines.svh"

module sce_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic signed [sce_pkg::LOGIT_W-1:0] logit_value,
	input logic        [sce_pkg::TOKEN_W-1:0] target_token,
	input logic                               last_in_batch,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [sce_pkg::LOGIT_W-1:0] mean_loss,
	input logic        [sce_pkg::COUNT_W-1:0] rows_counted,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic        [sce_pkg::VOCAB_W-1:0] row_len
);

	// Hold a stalled result
	`SCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(mean_loss) && $stable(rows_counted))

	// Take no item while a result waits
	`SCE_ASSERT_IMPL(a_no_take_while_out, out_valid, !in_ready && !cfg_ready)

	// An empty batch reports a zero mean
	`SCE_ASSERT_IMPL(a_empty_mean, out_valid && rows_counted == '0, mean_loss == '0)

	// Only the batch marker produces a result
	`SCE_ASSERT_NEXT(a_marker_only, in_valid && in_ready && !last_in_batch, !out_valid)

	// A taken result leaves at once
	`SCE_ASSERT_NEXT(a_out_drop, out_valid && out_ready, !out_valid)

endmodule

bind softmax_cross_entropy_loss_core sce_checker u_sce_checker (.*);

### dv/testbench.sv
// Self-checking testbench for softmax_cross_entropy_loss_core: a directed table,
// then random batches, checked against a fixed-point loss predictor or, for typed table rows, given results.
// Depends on sce_pkg and the core RTL only.
module testbench;

	localparam longint LN2_FX   = 45426;
	localparam longint ONE_FX   = 65536;
	localparam longint SUM_MAX  = (longint'(1) << 47) - 1;
	localparam longint SUM_MIN  = -(longint'(1) << 47);
	localparam int     RAND_ITEMS = 1150;

	typedef enum bit {DIR_CFG, DIR_ITEM} dir_kind_t;

	typedef struct {
		dir_kind_t   kind;
		int unsigned cfg_val;
		int          logit;
		int unsigned token;
		bit          is_last;
		bit          typed;
		int          mean;
		int unsigned rows;
	} dir_row_t;

	typedef struct {
		int          mean;
		int unsigned rows;
	} batch_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic signed [sce_pkg::LOGIT_W-1:0] logit_value;
	logic        [sce_pkg::TOKEN_W-1:0] target_token;
	logic                               last_in_batch;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [sce_pkg::LOGIT_W-1:0] mean_loss;
	logic        [sce_pkg::COUNT_W-1:0] rows_counted;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic        [sce_pkg::VOCAB_W-1:0] row_len;

	// Predictor state
	logic [sce_pkg::VOCAB_W-1:0] pred_vocab;
	int                          row_buf [sce_pkg::VOCAB_MAX];
	int unsigned                 elem_idx;
	int unsigned                 row_tgt;
	int unsigned                 prev_tgt;
	bit                          have_prev;
	longint                      loss_sum;
	int unsigned                 row_cnt;

	batch_result_t expected_batches[$];
	int            mismatches;
	int            tx_idle;
	int            rx_idle;
	bit            last_was_marker;

	dir_row_t directed [] = '{
		'{DIR_ITEM, 0, 0, 0, 1'b1, 1'b1, 0, 0},
		'{DIR_CFG, 8191, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h7fffffff, 16'hffff, 1'b1, 1'b1, 0, 0},
		'{DIR_CFG, 0, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h7fffffff, 0, 1'b1, 1'b1, 0, 1},
		'{DIR_CFG, 1, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 0, 1, 1'b1, 1'b1, 0, 0},
		'{DIR_CFG, 2, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h7fffffff, 1, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h80000000, 0, 1'b1, 1'b1, 32'h7fffffff, 1},
		'{DIR_ITEM, 0, 32'h00010000, 16'hffff, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00020000, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00008000, 1, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00030000, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00050000, 1, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'hfffe0000, 0, 1'b1, 1'b0, 0, 0},
		'{DIR_CFG, 8, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00010000, 3, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00020000, 0, 1'b1, 1'b1, 0, 0},
		'{DIR_ITEM, 0, 32'h00011000, 2, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'hffff0000, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00004000, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_CFG, 2, 0, 0, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00070000, 5, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00002000, 1, 1'b0, 1'b0, 0, 0},
		'{DIR_ITEM, 0, 32'h00090000, 0, 1'b1, 1'b0, 0, 0}
	};

	softmax_cross_entropy_loss_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.logit_value  (logit_value),
		.target_token (target_token),
		.last_in_batch(last_in_batch),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_loss    (mean_loss),
		.rows_counted (rows_counted),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.row_len      (row_len)
	);

	always #1 clk = ~clk;

	// exp(-x) in Q16.16: range reduction by ln2, then an eight-term Taylor sum
	function automatic longint exp_neg_fx(longint unsigned x);
		longint unsigned k;
		longint unsigned r;
		longint unsigned t;
		longint          acc;
		k = x / LN2_FX;
		r = x - k * LN2_FX;
		t = ONE_FX;
		acc = ONE_FX;
		if (k > 16)
			return 0;
		for (int n = 1; n <= 8; n++) begin
			t = ((t * r) >> 16) / n;
			if (n % 2 == 1)
				acc -= longint'(t);
			else
				acc += longint'(t);
		end
		if (acc < 0)
			acc = 0;
		return longint'(longint'(acc) >>> k);
	endfunction

	// ln(s) in Q16.16 via the atanh series on the normalized mantissa
	function automatic longint log_fx(longint unsigned s);
		int              p;
		longint unsigned m;
		longint unsigned y;
		longint unsigned z;
		longint unsigned w;
		longint unsigned t;
		longint unsigned acc;
		if (s < ONE_FX)
			return 0;
		p = 63;
		while (p > 0 && s[p] == 1'b0)
			p--;
		m = p - 16;
		y = s >> m;
		z = ((y - ONE_FX) << 16) / (y + ONE_FX);
		w = (z * z) >> 16;
		t = z;
		acc = z;
		for (int d = 3; d <= 9; d += 2) begin
			t = (t * w) >> 16;
			acc += t / d;
		end
		return longint'(m * LN2_FX + 2 * acc);
	endfunction

	function automatic int unsigned gcd_of(int unsigned a, int unsigned b);
		int unsigned r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic int unsigned active_vocab();
		if (pred_vocab == 0)
			return 1;
		if (pred_vocab > sce_pkg::VOCAB_MAX)
			return sce_pkg::VOCAB_MAX;
		return pred_vocab;
	endfunction

	// Close a complete row: cross-entropy minus similarity bonus
	task automatic close_row(input int unsigned n);
		longint          mx;
		longint          ce;
		longint          bonus;
		longint unsigned esum;
		longint unsigned g;
		longint unsigned big;
		bonus = 0;
		esum = 0;
		if (row_tgt < n) begin
			mx = row_buf[0];
			for (int v = 1; v < n; v++)
				if (row_buf[v] > mx)
					mx = row_buf[v];
			for (int v = 0; v < n; v++)
				esum += exp_neg_fx(longint'(mx - row_buf[v]));
			ce = log_fx(esum) + (mx - row_buf[row_tgt]);
			if (have_prev && prev_tgt < n && row_tgt != 0 && prev_tgt != 0) begin
				g = gcd_of(row_tgt + 1, prev_tgt + 1);
				big = ((row_tgt > prev_tgt) ? row_tgt : prev_tgt) + 1;
				bonus = longint'((g * ONE_FX + 50 * big) / (100 * big));
			end
			loss_sum += ce - bonus;
			if (loss_sum > SUM_MAX)
				loss_sum = SUM_MAX;
			if (loss_sum < SUM_MIN)
				loss_sum = SUM_MIN;
			if (row_cnt < 65535)
				row_cnt++;
		end
		prev_tgt = row_tgt;
		have_prev = 1'b1;
	endtask

	// Advance the predictor by one accepted item
	task automatic predict_item(input int logit, input int unsigned token, input bit is_last,
		output bit got, output batch_result_t res);
		int unsigned n;
		longint      mean;
		n = active_vocab();
		got = 1'b0;
		res = '{0, 0};
		if (elem_idx == 0)
			row_tgt = token;
		if (elem_idx < sce_pkg::VOCAB_MAX)
			row_buf[elem_idx] = logit;
		elem_idx++;
		if (elem_idx >= n) begin
			close_row(n);
			elem_idx = 0;
		end
		if (is_last) begin
			mean = 0;
			if (row_cnt > 0) begin
				mean = loss_sum / longint'(row_cnt);
				if (mean > 64'sd2147483647)
					mean = 64'sd2147483647;
				if (mean < -64'sd2147483648)
					mean = -64'sd2147483648;
			end
			got = 1'b1;
			res = '{int'(mean), row_cnt};
			elem_idx = 0;
			have_prev = 1'b0;
			loss_sum = 0;
			row_cnt = 0;
		end
	endtask

	// Present one item, hold it until taken, then predict
	task automatic send_item(input int logit, input int unsigned token, input bit is_last,
		input bit typed, input batch_result_t typed_res);
		bit            got;
		batch_result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		logit_value = logit;
		target_token = token[sce_pkg::TOKEN_W-1:0];
		last_in_batch = is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(logit, token, is_last, got, res);
		if (got)
			expected_batches.push_back(typed ? typed_res : res);
		last_was_marker = is_last;
	endtask

	// Write the row length once the core is idle
	task automatic write_vocab(input int unsigned value);
		int drain;
		@(negedge clk);
		in_valid = 1'b0;
		wait (expected_batches.size() == 0);
		drain = last_was_marker ? 8 : 21 * active_vocab() + 400;
		repeat (drain) @(negedge clk);
		cfg_valid = 1'b1;
		row_len = value[sce_pkg::VOCAB_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pred_vocab = value[sce_pkg::VOCAB_W-1:0];
		last_was_marker = 1'b1;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_logit(input bit wide, input int base);
		if (wide)
			return int'($urandom());
		return base + int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
	endfunction

	// Receiver stalls
	always @(negedge clk)
		out_ready = ($urandom_range(0, 99) >= rx_idle);

	// Check each taken result against the oldest expectation
	always @(posedge clk) begin
		batch_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_batches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result mean=%0d rows=%0d", mean_loss, rows_counted);
			end else begin
				exp_res = expected_batches.pop_front();
				if (mean_loss !== exp_res.mean ||
					rows_counted !== exp_res.rows[sce_pkg::COUNT_W-1:0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: mean exp %0d got %0d, rows exp %0d got %0d",
							exp_res.mean, mean_loss, exp_res.rows, rows_counted);
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int            sent;
		int unsigned   v;
		int            nrows;
		int unsigned   tgt;
		int            base;
		bit            wide;
		bit            cut;
		int            cut_at;
		int unsigned   pick;
		batch_result_t typed_res;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		logit_value = '0;
		target_token = '0;
		last_in_batch = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		row_len = '0;
		mismatches = 0;
		tx_idle = 29;
		rx_idle = 66;
		pred_vocab = 13'd4096;
		elem_idx = 0;
		row_tgt = 0;
		prev_tgt = 0;
		have_prev = 1'b0;
		loss_sum = 0;
		row_cnt = 0;
		last_was_marker = 1'b1;
		foreach (row_buf[i])
			row_buf[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (directed[i]) begin
			if (directed[i].kind == DIR_CFG) begin
				write_vocab(directed[i].cfg_val);
			end else begin
				typed_res = '{directed[i].mean, directed[i].rows};
				send_item(directed[i].logit, directed[i].token, directed[i].is_last,
					directed[i].typed, typed_res);
			end
		end

		// Random batches, small vocabularies mostly
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent < RAND_ITEMS / 3) begin
				tx_idle = 29;
				rx_idle = 66;
			end else if (sent < 2 * RAND_ITEMS / 3) begin
				tx_idle = 66;
				rx_idle = 29;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			v = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			write_vocab(v);
			nrows = $urandom_range(0, 5);
			if (nrows == 0) begin
				send_item(int'($urandom()), $urandom_range(0, 65535), 1'b1, 1'b0, typed_res);
				sent++;
			end
			for (int r = 0; r < nrows; r++) begin
				pick = $urandom_range(0, 9);
				if (pick < 8)
					tgt = $urandom_range(0, v - 1);
				else if (pick == 8)
					tgt = $urandom_range(0, 65535);
				else
					tgt = v;
				wide = ($urandom_range(0, 3) == 0);
				base = int'($urandom());
				cut = (r == nrows - 1) && ($urandom_range(0, 9) == 0) && v > 1;
				cut_at = cut ? $urandom_range(0, v - 2) : v - 1;
				for (int e = 0; e <= cut_at; e++) begin
					send_item(pick_logit(wide, base), (e == 0) ? tgt : $urandom_range(0, 65535),
						(r == nrows - 1) && (e == cut_at), 1'b0, typed_res);
					sent++;
				end
			end
		end

		// Drain
		@(negedge clk);
		in_valid = 1'b0;
		wait (expected_batches.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
